### sv/lzbd_pkg.sv
// Shared types and codes for the LZ back-reference decompressor.
`timescale 1ns / 1ps
package lzbd_pkg;

  localparam int OUT_COUNT_BITS = 24;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_STREAM  = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_OFFSET = 2'd1;
  localparam logic [1:0] ERR_CMD    = 2'd2;

  localparam logic CFG_XOR_ENABLE = 1'b0;
  localparam logic CFG_XOR_KEY    = 1'b1;

  typedef enum logic [5:0] {
    PH_CMD   = 6'b000001,
    PH_SIZE2 = 6'b000010,
    PH_OFF1  = 6'b000100,
    PH_OFF2  = 6'b001000,
    PH_LIT   = 6'b010000,
    PH_COPY  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                      emit;
    logic                      copy;
    logic [7:0]                lit;
    logic [1:0]                err;
    logic                      busy;
    logic [OUT_COUNT_BITS-1:0] total;
  } step_t;

endpackage

### sv/lzbd_in_if.sv
// Input and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface lzbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        copy_busy;
  logic [1:0]  error_code;
  logic [23:0] produced_total;

  modport source (output valid, output out_byte, output out_valid, output copy_busy,
                  output error_code, output produced_total, input ready);
  modport sink (input valid, input out_byte, input out_valid, input copy_busy,
                input error_code, input produced_total, output ready);
endinterface

### sv/lzbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### sv/lzbd_ctrl.sv
// Stream parser: chunk header decode, window pointers and produced count.
`timescale 1ns / 1ps
module lzbd_ctrl
  import lzbd_pkg::*;
#(
  parameter int WINDOW_BYTES = 32768,
  parameter int COUNT_BITS   = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [1:0]                      command,
  input  logic [7:0]                      data_byte,
  output step_t                           step,
  output logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
  output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int XW = AW + 2;
  localparam logic [XW-1:0] WIN = XW'(WINDOW_BYTES);

  phase_t                phase_r, phase_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [13:0]           len_r, len_nxt;
  logic [15:0]           off_r, off_nxt;
  logic                  lit_r, lit_nxt;
  logic [14:0]           left_r, left_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic          start;
  logic [XW-1:0] wp_x, off_x, src_x, wp_inc;
  logic [31:0]   cnt_wide;

  always_comb begin
    wp_x  = XW'(wp_r);
    off_x = XW'(off_r);
    if (wp_x >= off_x) begin
      src_x = wp_x - off_x;
    end else begin
      src_x = wp_x + WIN - off_x;
    end
    if (src_x >= WIN) begin
      src_x = '0;
    end
    wp_inc = wp_x + XW'(1);
  end

  assign rd_addr = src_x[AW-1:0];
  assign wr_addr = wp_r;

  always_comb begin
    phase_nxt = phase_r;
    wp_nxt    = wp_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    lit_nxt   = lit_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    start     = 1'b0;
    step.emit = 1'b0;
    step.copy = 1'b0;
    step.lit  = data_byte;
    step.err  = ERR_OK;

    unique case (command)
      CMD_STREAM: begin
        phase_nxt = PH_CMD;
        wp_nxt    = '0;
        len_nxt   = '0;
        off_nxt   = '0;
        lit_nxt   = 1'b0;
        left_nxt  = '0;
        cnt_nxt   = '0;
      end
      CMD_ADVANCE: begin
        if (phase_r == PH_COPY) begin
          step.emit = 1'b1;
          step.copy = 1'b1;
          left_nxt  = left_r - 15'd1;
          if (left_nxt == '0) begin
            phase_nxt = PH_CMD;
          end
        end else begin
          step.err = ERR_CMD;
        end
      end
      CMD_BYTE: begin
        unique case (phase_r)
          PH_CMD: begin
            lit_nxt = data_byte[6];
            len_nxt = {8'd0, data_byte[5:0]};
            if (data_byte[7]) begin
              phase_nxt = PH_SIZE2;
            end else if (data_byte[6]) begin
              start = 1'b1;
            end else begin
              phase_nxt = PH_OFF1;
            end
          end
          PH_SIZE2: begin
            len_nxt = {len_r[5:0], data_byte};
            if (lit_r) begin
              start = 1'b1;
            end else begin
              phase_nxt = PH_OFF1;
            end
          end
          PH_OFF1: begin
            if (data_byte[7]) begin
              off_nxt   = {9'd0, data_byte[6:0]};
              phase_nxt = PH_OFF2;
            end else begin
              off_nxt = {9'd0, data_byte[6:0]} + 16'd1;
              start   = 1'b1;
            end
          end
          PH_OFF2: begin
            off_nxt = {1'b0, off_r[6:0], data_byte} + 16'd1;
            start   = 1'b1;
          end
          PH_LIT: begin
            step.emit = 1'b1;
            if (left_r != '0) begin
              left_nxt = left_r - 15'd1;
            end
            if (left_nxt == '0) begin
              phase_nxt = PH_CMD;
            end
          end
          PH_COPY: begin
            step.err = ERR_CMD;
          end
          default: begin
            step.err = ERR_CMD;
          end
        endcase
      end
      default: begin
        step.err = ERR_CMD;
      end
    endcase

    if (start) begin
      left_nxt = {1'b0, len_nxt} + 15'd1;
      if (lit_nxt) begin
        phase_nxt = PH_LIT;
      end else if (32'(off_nxt) > 32'(cnt_r)) begin
        phase_nxt = PH_CMD;
        left_nxt  = '0;
        step.err  = ERR_OFFSET;
      end else begin
        phase_nxt = PH_COPY;
      end
    end

    if (step.emit) begin
      wp_nxt = (wp_inc == WIN) ? '0 : wp_inc[AW-1:0];
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end

    cnt_wide   = 32'(cnt_nxt);
    step.total = cnt_wide[OUT_COUNT_BITS-1:0];
    step.busy  = (phase_nxt == PH_COPY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      wp_r    <= '0;
      len_r   <= '0;
      off_r   <= '0;
      lit_r   <= 1'b0;
      left_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      lit_r   <= lit_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_copy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COPY |-> left_r != '0)
    else $error("copy phase with no bytes left");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && step.emit && cnt_r != '1 |=> cnt_r == $past(cnt_r) + COUNT_BITS'(1))
    else $error("produced count did not advance on emitted byte");

  a_offset_err_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    step.err == ERR_OFFSET |-> !step.emit)
    else $error("byte emitted with offset error");

endmodule

### sv/lzbd_emit.sv
// Byte stage: window write, read forwarding, XOR and output register.
`timescale 1ns / 1ps
module lzbd_emit
  import lzbd_pkg::*;
#(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  step_t         step,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  input  logic          xor_enable,
  input  logic [7:0]    xor_key,
  output logic          in_ready,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  lzbd_out_if.source    out_ch
);

  logic          s1_v_r;
  step_t         s1_step_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_fwd_r;
  logic [7:0]    s1_fwd_data_r;

  logic        out_v_r, out_v_nxt;
  logic [7:0]  out_byte_r;
  logic        out_valid_r;
  logic        out_busy_r;
  logic [1:0]  out_err_r;
  logic [23:0] out_total_r;

  logic       s1_fire;
  logic [7:0] raw;
  logic [7:0] mask;

  always_comb begin
    if (!s1_step_r.emit) begin
      raw = 8'd0;
    end else if (s1_step_r.copy) begin
      if (s1_fwd_r) begin
        raw = s1_fwd_data_r;
      end else begin
        raw = rd_data;
      end
    end else begin
      raw = s1_step_r.lit;
    end
    mask = (xor_enable && s1_step_r.emit) ? xor_key : 8'd0;
  end

  assign s1_fire   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready  = !s1_v_r || s1_fire;
  assign ram_we    = s1_fire && s1_step_r.emit;
  assign ram_waddr = s1_addr_r;
  assign ram_wdata = raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  // Hold the in-flight byte for a read of the address it is about to write.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step_r     <= step;
      s1_addr_r     <= wr_addr;
      s1_fwd_r      <= s1_v_r && s1_step_r.emit && (s1_addr_r == rd_addr);
      s1_fwd_data_r <= raw;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r  <= raw ^ mask;
      out_valid_r <= s1_step_r.emit;
      out_busy_r  <= s1_step_r.busy;
      out_err_r   <= s1_step_r.err;
      out_total_r <= s1_step_r.total;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.out_valid      = out_valid_r;
  assign out_ch.copy_busy      = out_busy_r;
  assign out_ch.error_code     = out_err_r;
  assign out_ch.produced_total = out_total_r;

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_valid_r |-> out_byte_r == 8'd0)
    else $error("nonzero byte on result without produced byte");

  a_write_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> s1_v_r && (!out_v_r || out_ch.ready))
    else $error("window write without stage transfer");

  a_accept_frees_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_v_r |-> s1_fire)
    else $error("new item overwrote held stage");

endmodule

### sv/lz_backref_decompressor_top.sv
// A result is registered in the byte stage and then in the output register before it can transfer.
// Throughput: one item per cycle without result stalls; the window RAM does one write and
//   one read per cycle, with the byte in flight forwarded to a read of the same address.
// Reset clears parser state, pointers, counts, config and pipeline valids.
// The history window is not cleared; entries read only after being written.
`timescale 1ns / 1ps
module lz_backref_decompressor_top
  import lzbd_pkg::*;
#(
  parameter int WINDOW_BYTES = 32768,
  parameter int COUNT_BITS   = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  lzbd_in_if.sink    in_ch,
  lzbd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic          xor_enable_r;
  logic [7:0]    xor_key_r;
  logic          accept;
  logic          in_ready;
  step_t         step;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_enable_r <= 1'b0;
      xor_key_r    <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_XOR_ENABLE: xor_enable_r <= cfg_data[0];
        CFG_XOR_KEY:    xor_key_r    <= cfg_data;
        default:        xor_key_r    <= xor_key_r;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  lzbd_ctrl #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .command  (in_ch.command),
    .data_byte(in_ch.data_byte),
    .step     (step),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  lzbd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_window (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (accept),
    .raddr  (rd_addr),
    .rdata_r(rd_data)
  );

  lzbd_emit #(
    .AW(AW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .step      (step),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .xor_enable(xor_enable_r),
    .xor_key   (xor_key_r),
    .in_ready  (in_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .out_ch    (out_ch)
  );

endmodule

### verif/lz_backref_decompressor_top_tb.sv
// Self-checking testbench for the LZ back-reference decompressor top level.
`timescale 1ns / 1ps
module lz_backref_decompressor_top_tb;
  import lzbd_pkg::*;

  localparam int WIN_BYTES = 32768;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } lz_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        copy_busy;
    logic [1:0]  error_code;
    logic [23:0] produced_total;
  } lz_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  lzbd_in_if  in_ch();
  lzbd_out_if out_ch();

  lz_backref_decompressor_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // decoder shadow state
  logic [7:0]  hist_mem [WIN_BYTES];
  int unsigned wr_ptr;
  phase_t      phase;
  logic [13:0] chunk_len;
  int unsigned back_off;
  logic        lit_chunk;
  int unsigned left_cnt;
  logic [23:0] produced;
  logic        xor_on;
  logic [7:0]  xor_byte;

  lz_item_t   item_q[$];
  lz_result_t byte_expect_q[$];

  int gen_count;
  int queued;
  int accepted_cnt;
  int fail_cnt;
  int cyc;
  int send_gap;
  int rx_gap;
  int hold_left;
  bit hold_done;
  bit tx_quiet;
  bit rx_quiet;
  int lit_bytes, copy_bytes, offset_faults, cmd_rejects, stream_starts, key_settings;

  function automatic void reset_stream();
    wr_ptr    = 0;
    phase     = PH_CMD;
    chunk_len = '0;
    back_off  = 0;
    lit_chunk = 1'b0;
    left_cnt  = 0;
    produced  = '0;
  endfunction

  function automatic logic [7:0] emit_byte(logic [7:0] raw);
    hist_mem[wr_ptr] = raw;
    wr_ptr = (wr_ptr + 1 >= WIN_BYTES) ? 0 : wr_ptr + 1;
    if (produced != 24'hFFFFFF) produced++;
    return xor_on ? (raw ^ xor_byte) : raw;
  endfunction

  function automatic logic [1:0] open_chunk();
    left_cnt = chunk_len + 1;
    if (lit_chunk) begin
      phase = PH_LIT;
      return ERR_OK;
    end
    if (back_off > produced) begin
      phase = PH_CMD;
      left_cnt = 0;
      return ERR_OFFSET;
    end
    phase = PH_COPY;
    return ERR_OK;
  endfunction

  function automatic lz_result_t decode_item(logic [1:0] cmd, logic [7:0] b);
    lz_result_t  r;
    int unsigned src;
    r = '0;
    case (cmd)
      CMD_STREAM: begin
        reset_stream();
        stream_starts++;
      end
      CMD_ADVANCE: begin
        if (phase == PH_COPY) begin
          src = (wr_ptr >= back_off) ? wr_ptr - back_off : wr_ptr + WIN_BYTES - back_off;
          r.out_byte = emit_byte(hist_mem[src]);
          r.out_valid = 1'b1;
          copy_bytes++;
          left_cnt--;
          if (left_cnt == 0) phase = PH_CMD;
        end else begin
          r.error_code = ERR_CMD;
        end
      end
      CMD_BYTE: begin
        case (phase)
          PH_CMD: begin
            lit_chunk = b[6];
            chunk_len = {8'd0, b[5:0]};
            if (b[7]) phase = PH_SIZE2;
            else if (lit_chunk) r.error_code = open_chunk();
            else phase = PH_OFF1;
          end
          PH_SIZE2: begin
            chunk_len = {chunk_len[5:0], b};
            if (lit_chunk) r.error_code = open_chunk();
            else phase = PH_OFF1;
          end
          PH_OFF1: begin
            back_off = 32'(b[6:0]);
            if (b[7]) begin
              phase = PH_OFF2;
            end else begin
              back_off = back_off + 1;
              r.error_code = open_chunk();
            end
          end
          PH_OFF2: begin
            back_off = {back_off[6:0], b} + 1;
            r.error_code = open_chunk();
          end
          PH_LIT: begin
            r.out_byte = emit_byte(b);
            r.out_valid = 1'b1;
            lit_bytes++;
            if (left_cnt > 0) left_cnt--;
            if (left_cnt == 0) phase = PH_CMD;
          end
          default: r.error_code = ERR_CMD;
        endcase
      end
      default: r.error_code = ERR_CMD;
    endcase
    if (r.error_code == ERR_OFFSET) offset_faults++;
    if (r.error_code == ERR_CMD) cmd_rejects++;
    r.copy_busy = (phase == PH_COPY);
    r.produced_total = produced;
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // cycle count, idle-pattern windows and timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[7:0] == 8'd0) begin
      tx_quiet <= ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
    end
    if (cyc == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    logic take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        byte_expect_q.push_back(decode_item(in_ch.command, in_ch.data_byte));
        void'(item_q.pop_front());
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_ch.valid && !take) begin
        // hold until transfer
      end else if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (item_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.command <= item_q[0].cmd;
        in_ch.data_byte <= item_q[0].data;
        send_gap <= pick_gap(tx_quiet);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, triggered once
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (accepted_cnt == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    lz_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (byte_expect_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt++;
        end else begin
          want = byte_expect_q.pop_front();
          check_field("out_byte", 24'(want.out_byte), 24'(out_ch.out_byte));
          check_field("out_valid", 24'(want.out_valid), 24'(out_ch.out_valid));
          check_field("copy_busy", 24'(want.copy_busy), 24'(out_ch.copy_busy));
          check_field("error_code", 24'(want.error_code), 24'(out_ch.error_code));
          check_field("produced_total", want.produced_total, out_ch.produced_total);
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        out_ch.ready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap <= pick_gap(rx_quiet);
      end
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [7:0] b);
    item_q.push_back('{cmd, b});
    queued++;
  endtask

  task automatic push_header(int len, logic lit);
    logic [13:0] code;
    code = 14'(len - 1);
    if (code > 63 || $urandom_range(0, 9) == 0) begin
      push_item(CMD_BYTE, {1'b1, lit, code[13:8]});
      push_item(CMD_BYTE, code[7:0]);
    end else begin
      push_item(CMD_BYTE, {1'b0, lit, code[5:0]});
    end
  endtask

  task automatic gen_literal(int len);
    int k;
    push_header(len, 1'b1);
    for (k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(0, 49) == 0) item_q.push_back('{CMD_ADVANCE, 8'($urandom)});
      push_item(CMD_BYTE, 8'($urandom));
    end
    gen_count += len;
  endtask

  task automatic gen_copy(int len, int off);
    logic [14:0] oc;
    int k;
    push_header(len, 1'b0);
    oc = 15'(off - 1);
    if (oc > 127 || $urandom_range(0, 9) == 0) begin
      push_item(CMD_BYTE, {1'b1, oc[14:8]});
      push_item(CMD_BYTE, oc[7:0]);
    end else begin
      push_item(CMD_BYTE, {1'b0, oc[6:0]});
    end
    if (off <= gen_count) begin
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 49) == 0) item_q.push_back('{CMD_BYTE, 8'($urandom)});
        else if ($urandom_range(0, 49) == 0) item_q.push_back('{CMD_RESERVED, 8'($urandom)});
        push_item(CMD_ADVANCE, 8'($urandom));
      end
      gen_count += len;
    end
  endtask

  function automatic int chunk_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 4);
    if (roll < 85) return $urandom_range(5, 16);
    if (roll < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 300);
  endfunction

  task automatic random_burst(int n);
    int goal;
    int pick;
    int len;
    int cap;
    goal = queued + n;
    push_item(CMD_STREAM, 8'($urandom));
    gen_count = 0;
    while (queued < goal) begin
      pick = $urandom_range(0, 99);
      cap = (gen_count > WIN_BYTES) ? WIN_BYTES : gen_count;
      if (pick < 35 || gen_count == 0) begin
        gen_literal(chunk_size());
      end else if (pick < 75) begin
        gen_copy(chunk_size(), ($urandom_range(0, 2) != 0) ?
                 $urandom_range(1, (cap < 8) ? cap : 8) : $urandom_range(1, cap));
      end else if (pick < 81) begin
        gen_copy(chunk_size(), $urandom_range(gen_count + 1, WIN_BYTES));
      end else if (pick < 87) begin
        if ($urandom_range(0, 1)) item_q.push_back('{CMD_RESERVED, 8'($urandom)});
        else item_q.push_back('{CMD_ADVANCE, 8'($urandom)});
      end else if (pick < 95) begin
        // cut a chunk short, then restart the stream
        case ($urandom_range(0, 2))
          0: begin
            len = $urandom_range(2, 40);
            push_header(len, 1'b1);
            repeat ($urandom_range(0, len - 1)) push_item(CMD_BYTE, 8'($urandom));
          end
          1: begin
            push_header(chunk_size(), 1'b0);
            if ($urandom_range(0, 1)) push_item(CMD_BYTE, {1'b1, 7'($urandom)});
          end
          default: push_item(CMD_BYTE, {1'b1, 7'($urandom)});
        endcase
        push_item(CMD_STREAM, 8'($urandom));
        gen_count = 0;
      end else begin
        push_item(CMD_STREAM, 8'($urandom));
        gen_count = 0;
      end
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || byte_expect_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_XOR_ENABLE) xor_on = value[0];
    else xor_byte = value;
  endtask

  task automatic apply_xor(logic en, logic [7:0] key);
    write_reg(CFG_XOR_ENABLE, {7'd0, en});
    write_reg(CFG_XOR_KEY, key);
    key_settings++;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_BYTE;
    in_ch.data_byte = 8'd0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_XOR_ENABLE;
    cfg_data = 8'd0;
    rst_n = 1'b0;
    xor_on = 1'b0;
    xor_byte = 8'd0;
    reset_stream();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rejects, literal, copy, bad offset, long forms, restart mid-chunk
    push_item(CMD_STREAM, 8'h00);
    push_item(CMD_ADVANCE, 8'hFF);
    push_item(CMD_RESERVED, 8'hFF);
    push_item(CMD_BYTE, 8'h42);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'hA5);
    push_item(CMD_BYTE, 8'h01);
    push_item(CMD_BYTE, 8'h02);
    push_item(CMD_ADVANCE, 8'h00);
    push_item(CMD_BYTE, 8'h11);
    push_item(CMD_ADVANCE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'hC0);
    push_item(CMD_BYTE, 8'h01);
    push_item(CMD_BYTE, 8'h5A);
    push_item(CMD_BYTE, 8'h3C);
    push_item(CMD_BYTE, 8'h80);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h84);
    push_item(CMD_BYTE, 8'h04);
    push_item(CMD_ADVANCE, 8'h00);
    push_item(CMD_BYTE, 8'h42);
    push_item(CMD_BYTE, 8'h77);
    push_item(CMD_STREAM, 8'h00);
    wait_drained();

    // long length and offset forms, far and overlapping copies
    apply_xor(1'b1, 8'h5A);
    push_item(CMD_STREAM, 8'h00);
    gen_count = 0;
    gen_literal(200);
    gen_copy(150, 200);
    gen_literal(100);
    gen_copy(20, 450);
    gen_copy(64, 1);
    wait_drained();

    apply_xor(1'b0, 8'hFF);
    random_burst(190);
    wait_drained();
    apply_xor(1'b1, 8'hFF);
    random_burst(190);
    wait_drained();
    apply_xor(1'b1, 8'h00);
    random_burst(190);
    wait_drained();
    apply_xor(1'b0, 8'h00);
    random_burst(190);
    wait_drained();
    apply_xor(1'b1, 8'($urandom_range(1, 254)));
    random_burst(190);
    wait_drained();

    $display("Run: %0d items in, %0d literal and %0d copied bytes out, %0d stream starts",
             accepted_cnt, lit_bytes, copy_bytes, stream_starts);
    $display("     %0d bad offsets, %0d rejected commands, %0d XOR settings",
             offset_faults, cmd_rejects, key_settings);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
